// ===== rtl/core/sadp_pkg.sv =====
package sadp_pkg;

  // field widths of the streamed element and the result
  localparam int unsigned WeightW = 8;
  localparam int unsigned ActW    = 16;
  localparam int unsigned BiasW   = 32;
  localparam int unsigned MultW   = 8;
  localparam int unsigned ProdW   = WeightW + ActW;
  localparam int unsigned ScaledW = 32;
  localparam int unsigned SumW    = 48;
  localparam int unsigned ResultW = 32;
  localparam int unsigned CountW  = 32;

  // configuration port
  localparam int unsigned CfgDataW  = 14;
  localparam int unsigned ChunkLenW = 14;
  localparam logic [ChunkLenW-1:0] ChunkLenReset = 14'd8192;

  // queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // int32 clamp bounds at accumulator width
  localparam logic signed [SumW-1:0] SumHi = 48'sh0000_7FFF_FFFF;
  localparam logic signed [SumW-1:0] SumLo = 48'shFFFF_8000_0000;

  // configuration register indexes
  typedef enum logic [0:0] {
    CfgChunkLength = 1'b0,
    CfgScaleEnable = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [WeightW-1:0] weight;
    logic signed [ActW-1:0]    activation;
    logic signed [BiasW-1:0]   row_bias;
    logic        [MultW-1:0]   row_multiplier;
    logic                      last_of_row;
  } in_item_t;

  typedef struct packed {
    logic signed [ResultW-1:0] dot_result;
    logic        [CountW-1:0]  saturation_count;
  } out_item_t;

  // queue entry: raw product, the factor the back end applies, bias and last flag
  typedef struct packed {
    logic signed [ProdW-1:0] prod;
    logic        [MultW-1:0] mult;
    logic signed [BiasW-1:0] bias;
    logic                    last;
  } q_entry_t;

endpackage

// ===== rtl/core/scaled_int8_affine_dot_product_unit.sv =====
// Affine dot-product unit: streams one int8 weight and signed activation per
// transfer and returns one saturated int32 result, with the running clamp count,
// for each row (on the element marked last_of_row). The bias is taken from the
// row's first element; in scaled mode each product is multiplied by that
// element's row multiplier. The sum is clamped to int32 after every
// chunk_length elements and at row end. The unit sustains one element per
// cycle unless a result is held back: a front end forms weight*activation
// into a two-entry queue, a scale stage applies the multiplier, and a 48-bit
// accumulate-and-clamp loop follows. A result is registered after the queue
// and the scale stage. Write configuration only while no element is in flight.
module scaled_int8_affine_dot_product_unit
  import sadp_pkg::*;
#(
  parameter int unsigned MaxChunk = 8192
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  cfg_idx_e            cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [ChunkLenW-1:0] chunk_len_q;
  logic                 scale_en_q;
  logic                 q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
  q_entry_t             q_wr_data, q_rd_data;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_len_q <= ChunkLenReset;
      scale_en_q  <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgChunkLength: chunk_len_q <= cfg_data_i[ChunkLenW-1:0];
        CfgScaleEnable: scale_en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  sadp_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .scale_en_i (scale_en_q),
    .q_valid_o  (q_wr_valid),
    .q_ready_i  (q_wr_ready),
    .q_data_o   (q_wr_data)
  );

  sadp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (q_wr_valid),
    .wr_ready_o (q_wr_ready),
    .wr_data_i  (q_wr_data),
    .rd_valid_o (q_rd_valid),
    .rd_ready_i (q_rd_ready),
    .rd_data_o  (q_rd_data)
  );

  sadp_back #(
    .MaxChunk (MaxChunk)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_rd_valid),
    .q_ready_o   (q_rd_ready),
    .q_data_i    (q_rd_data),
    .chunk_len_i (chunk_len_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/sadp_front.sv =====
module sadp_front
  import sadp_pkg::*;
(
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  input  logic     scale_en_i,
  output logic     q_valid_o,
  input  logic     q_ready_i,
  output q_entry_t q_data_o
);

  logic signed [ProdW-1:0] prod;

  // weight times activation
  assign prod = in_data_i.weight * in_data_i.activation;

  // unscaled mode multiplies by one in the back end
  always_comb begin
    q_data_o.prod = prod;
    q_data_o.mult = scale_en_i ? in_data_i.row_multiplier : MultW'(1);
    q_data_o.bias = in_data_i.row_bias;
    q_data_o.last = in_data_i.last_of_row;
  end

  // transfer into the queue
  assign q_valid_o  = in_valid_i;
  assign in_ready_o = q_ready_i;

endmodule

// ===== rtl/core/sadp_queue.sv =====
module sadp_queue
  import sadp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_valid_i,
  output logic     wr_ready_o,
  input  q_entry_t wr_data_i,
  output logic     rd_valid_o,
  input  logic     rd_ready_i,
  output q_entry_t rd_data_o
);

  q_entry_t         mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != QCntW'(QueueDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== rtl/core/sadp_back.sv =====
module sadp_back
  import sadp_pkg::*;
#(
  parameter int unsigned MaxChunk = 8192
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_ready_o,
  input  q_entry_t             q_data_i,
  input  logic [ChunkLenW-1:0] chunk_len_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o
);

  localparam int unsigned CW = $clog2(MaxChunk + 1);
  localparam int unsigned LW = (CW > ChunkLenW) ? CW : ChunkLenW;

  // scale stage
  logic                      s1_valid_q;
  logic signed [ScaledW-1:0] s1_prod_q;
  logic signed [BiasW-1:0]   s1_bias_q;
  logic                      s1_last_q;
  logic signed [ScaledW-1:0] mul_full;
  logic                      s1_ready, acc_take;

  // accumulator state
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [CW-1:0]          pos_q, pos_d;
  logic                   start_q, start_d;
  logic [CountW-1:0]      total_q, total_d;
  logic                   out_valid_q;
  out_item_t              out_q;

  logic signed [SumW-1:0] base, sum1, clamped;
  logic [CW-1:0]          pos1;
  logic [LW-1:0]          chunk_ext, eff_chunk;
  logic                   hit, do_clamp, over_hi, under_lo;

  assign acc_take  = s1_valid_q && (!s1_last_q || !out_valid_q || out_ready_i);
  assign s1_ready  = !s1_valid_q || acc_take;
  assign q_ready_o = s1_ready;

  // product times row factor
  assign mul_full = q_data_i.prod * $signed({1'b0, q_data_i.mult});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && q_valid_i) begin
      s1_prod_q <= mul_full;
      s1_bias_q <= q_data_i.bias;
      s1_last_q <= q_data_i.last;
    end
  end

  // effective chunk length: zero acts as one, capped at the maximum
  always_comb begin
    chunk_ext = LW'(chunk_len_i);
    if (chunk_ext == '0) begin
      eff_chunk = LW'(1);
    end else if (chunk_ext > LW'(MaxChunk)) begin
      eff_chunk = LW'(MaxChunk);
    end else begin
      eff_chunk = chunk_ext;
    end
  end

  // accumulate and clamp at chunk boundaries and row end
  always_comb begin
    base     = start_q ? {{(SumW-BiasW){s1_bias_q[BiasW-1]}}, s1_bias_q} : sum_q;
    sum1     = base + {{(SumW-ScaledW){s1_prod_q[ScaledW-1]}}, s1_prod_q};
    pos1     = (start_q ? '0 : pos_q) + CW'(1);
    hit      = (LW'(pos1) >= eff_chunk);
    do_clamp = hit || s1_last_q;
    over_hi  = (sum1 > SumHi);
    under_lo = (sum1 < SumLo);
    clamped  = sum1;
    if (do_clamp && over_hi) begin
      clamped = SumHi;
    end else if (do_clamp && under_lo) begin
      clamped = SumLo;
    end
    total_d = total_q;
    if (do_clamp && (over_hi || under_lo)) begin
      total_d = total_q + CountW'(1);
    end
    if (s1_last_q) begin
      sum_d   = '0;
      pos_d   = '0;
      start_d = 1'b1;
    end else begin
      sum_d   = clamped;
      pos_d   = hit ? '0 : pos1;
      start_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      pos_q       <= '0;
      start_q     <= 1'b1;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc_take) begin
        sum_q   <= sum_d;
        pos_q   <= pos_d;
        start_q <= start_d;
        total_q <= total_d;
      end
      if (acc_take && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (acc_take && s1_last_q) begin
      out_q.dot_result       <= clamped[ResultW-1:0];
      out_q.saturation_count <= total_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
